/* design/sic_pkg.sv */
package sic_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int OUT_BITS       = 48;
  // divider: product, shift, range check, then one quotient bit per stage
  localparam int DIV_LAT        = OUT_BITS + 3;
  localparam int QDEPTH         = 8;
  localparam int FRONT_LAT      = 3;

  typedef enum logic [2:0] {
    REL_DISJOINT,
    REL_POINT,
    REL_OVERLAP,
    REL_A_HIT,
    REL_B_HIT,
    REL_LINES
  } rel_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

endpackage

/* design/sic_div.sv */
module sic_div import sic_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic [COORD_BITS-1:0]      dir,
  input  logic [2*COORD_BITS+1:0]    num,
  input  logic [2*COORD_BITS+1:0]    den,
  output logic [OUT_BITS-1:0]        quo,
  output logic                       ovf
);

  localparam int MW  = 2*COORD_BITS + 2;
  localparam int LOW = (MW + 1) / 2;
  localparam int HIW = MW - LOW;
  localparam int NW  = COORD_BITS + MW + FRAC_BITS;
  localparam int NX  = (NW > OUT_BITS) ? NW : OUT_BITS;
  localparam int RW  = MW + 1;

  logic [COORD_BITS+LOW-1:0] pl;
  logic [COORD_BITS+HIW-1:0] ph;
  logic [MW-1:0]             den_a, den_b;
  logic [NX-1:0]             nb;
  logic [NX+RW-1:0]          nh;

  logic [RW-1:0]       rem_r  [0:OUT_BITS];
  logic [OUT_BITS-1:0] nlow_r [0:OUT_BITS];
  logic [OUT_BITS-1:0] q_r    [0:OUT_BITS];
  logic [MW-1:0]       den_r  [0:OUT_BITS];
  logic                ovf_r  [0:OUT_BITS];

  always_ff @(posedge clk) begin
    pl    <= (COORD_BITS+LOW)'(dir) * (COORD_BITS+LOW)'(num[LOW-1:0]);
    ph    <= (COORD_BITS+HIW)'(dir) * (COORD_BITS+HIW)'(num[MW-1:LOW]);
    den_a <= den;
    nb    <= ((NX'(ph) << LOW) + NX'(pl)) << FRAC_BITS;
    den_b <= den_a;
  end

  // quotient beyond the output range shows as a high part not below den
  assign nh = (NX+RW)'(nb) >> OUT_BITS;

  always_ff @(posedge clk) begin
    rem_r[0]  <= nh[RW-1:0];
    nlow_r[0] <= nb[OUT_BITS-1:0];
    q_r[0]    <= '0;
    den_r[0]  <= den_b;
    ovf_r[0]  <= nh >= (NX+RW)'(den_b);
  end

  for (genvar k = 0; k < OUT_BITS; k++) begin : g_step
    logic [RW-1:0] t;
    logic          ge;
    always_comb begin
      t  = {rem_r[k][MW-1:0], nlow_r[k][OUT_BITS-1-k]};
      ge = t >= {1'b0, den_r[k]};
    end
    always_ff @(posedge clk) begin
      rem_r[k+1]  <= ge ? t - {1'b0, den_r[k]} : t;
      nlow_r[k+1] <= nlow_r[k];
      q_r[k+1]    <= {q_r[k][OUT_BITS-2:0], ge};
      den_r[k+1]  <= den_r[k];
      ovf_r[k+1]  <= ovf_r[k];
    end
  end

  assign quo = q_r[OUT_BITS];
  assign ovf = ovf_r[OUT_BITS];

endmodule

/* design/sic_front.sv */
module sic_front import sic_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] ax0,
  input  logic signed [COORD_BITS-1:0] ay0,
  input  logic signed [COORD_BITS-1:0] ax1,
  input  logic signed [COORD_BITS-1:0] ay1,
  input  logic signed [COORD_BITS-1:0] bx0,
  input  logic signed [COORD_BITS-1:0] by0,
  input  logic signed [COORD_BITS-1:0] bx1,
  input  logic signed [COORD_BITS-1:0] by1,
  output logic                         out_valid,
  output logic [2:0]                   rel,
  output logic                         line,
  output logic                         negx,
  output logic                         negy,
  output logic [COORD_BITS-1:0]        dirx,
  output logic [COORD_BITS-1:0]        diry,
  output logic [2*COORD_BITS+1:0]      num,
  output logic [2*COORD_BITS+1:0]      den,
  output logic signed [COORD_BITS-1:0] px,
  output logic signed [COORD_BITS-1:0] py,
  output logic signed [COORD_BITS-1:0] hx,
  output logic signed [COORD_BITS-1:0] hy
);

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;
  localparam int PW = 2*DW;
  localparam int CW = PW + 1;
  localparam int MW = 2*CB + 2;

  // stage 1: coordinates and differences
  logic                 s1_v;
  logic signed [CB-1:0] s1_ax0, s1_ay0, s1_ax1, s1_ay1, s1_bx0, s1_by0, s1_bx1, s1_by1;
  logic signed [DW-1:0] s1_ux, s1_uy, s1_vx, s1_vy, s1_wx, s1_wy, s1_mx, s1_my;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= in_valid;
    end
    s1_ax0 <= ax0; s1_ay0 <= ay0; s1_ax1 <= ax1; s1_ay1 <= ay1;
    s1_bx0 <= bx0; s1_by0 <= by0; s1_bx1 <= bx1; s1_by1 <= by1;
    s1_ux  <= DW'(ax1) - DW'(ax0);
    s1_uy  <= DW'(ay1) - DW'(ay0);
    s1_vx  <= DW'(bx1) - DW'(bx0);
    s1_vy  <= DW'(by1) - DW'(by0);
    s1_wx  <= DW'(ax0) - DW'(bx0);
    s1_wy  <= DW'(ay0) - DW'(by0);
    s1_mx  <= DW'(ax1) - DW'(bx0);
    s1_my  <= DW'(ay1) - DW'(by0);
  end

  // stage 2: cross product terms, collinear parameters along b
  logic signed [DW:0]   n0, n1, dn, tmp;
  logic                 sw, wa, wb;
  logic signed [CB-1:0] c, l, h;

  always_comb begin
    tmp = '0;
    if (s1_vx != '0) begin
      n0 = (DW+1)'(s1_wx); n1 = (DW+1)'(s1_mx); dn = (DW+1)'(s1_vx);
    end else begin
      n0 = (DW+1)'(s1_wy); n1 = (DW+1)'(s1_my); dn = (DW+1)'(s1_vy);
    end
    if (dn < 0) begin
      n0 = -n0; n1 = -n1; dn = -dn;
    end
    sw = n0 > n1;
    if (sw) begin
      tmp = n0; n0 = n1; n1 = tmp;
    end
    // a0 within segment b, b0 within a; y used if vertical
    if (s1_bx0 == s1_bx1) begin
      c = s1_ay0; l = s1_by0; h = s1_by1;
    end else begin
      c = s1_ax0; l = s1_bx0; h = s1_bx1;
    end
    wa = (l <= c && c <= h) || (l >= c && c >= h);
    if (s1_ax0 == s1_ax1) begin
      c = s1_by0; l = s1_ay0; h = s1_ay1;
    end else begin
      c = s1_bx0; l = s1_ax0; h = s1_ax1;
    end
    wb = (l <= c && c <= h) || (l >= c && c >= h);
  end

  logic                 s2_v;
  logic signed [CB-1:0] s2_ax0, s2_ay0, s2_ax1, s2_ay1, s2_bx0, s2_by0, s2_bx1, s2_by1;
  logic signed [DW-1:0] s2_ux, s2_uy;
  logic signed [PW-1:0] s2_uv1, s2_uv2, s2_vw1, s2_vw2, s2_uw1, s2_uw2;
  logic signed [DW:0]   s2_n0, s2_n1, s2_dn;
  logic                 s2_sw, s2_upt, s2_vpt, s2_wa, s2_wb, s2_eqp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_ax0 <= s1_ax0; s2_ay0 <= s1_ay0; s2_ax1 <= s1_ax1; s2_ay1 <= s1_ay1;
    s2_bx0 <= s1_bx0; s2_by0 <= s1_by0; s2_bx1 <= s1_bx1; s2_by1 <= s1_by1;
    s2_ux  <= s1_ux;
    s2_uy  <= s1_uy;
    s2_uv1 <= PW'(s1_ux) * PW'(s1_vy);
    s2_uv2 <= PW'(s1_uy) * PW'(s1_vx);
    s2_vw1 <= PW'(s1_vx) * PW'(s1_wy);
    s2_vw2 <= PW'(s1_vy) * PW'(s1_wx);
    s2_uw1 <= PW'(s1_ux) * PW'(s1_wy);
    s2_uw2 <= PW'(s1_uy) * PW'(s1_wx);
    s2_n0  <= n0;
    s2_n1  <= n1;
    s2_dn  <= dn;
    s2_sw  <= sw;
    s2_upt <= s1_ux == '0 && s1_uy == '0;
    s2_vpt <= s1_vx == '0 && s1_vy == '0;
    s2_wa  <= wa;
    s2_wb  <= wb;
    s2_eqp <= s1_ax0 == s1_bx0 && s1_ay0 == s1_by0;
  end

  // stage 3: determinant, numerators, overlap clipping
  logic                 s3_v;
  logic signed [CB-1:0] s3_ax0, s3_ay0, s3_ax1, s3_ay1, s3_bx0, s3_by0, s3_bx1, s3_by1;
  logic signed [DW-1:0] s3_ux, s3_uy;
  logic signed [CW-1:0] s3_d, s3_sn, s3_tn;
  logic                 s3_dis, s3_lob, s3_hib, s3_ceq;
  logic                 s3_sw, s3_upt, s3_vpt, s3_wa, s3_wb, s3_eqp;
  logic signed [DW:0]   c0, c1;

  always_comb begin
    c0 = (s2_n0 < 0) ? '0 : s2_n0;
    c1 = (s2_n1 > s2_dn) ? s2_dn : s2_n1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= s2_v;
    end
    s3_ax0 <= s2_ax0; s3_ay0 <= s2_ay0; s3_ax1 <= s2_ax1; s3_ay1 <= s2_ay1;
    s3_bx0 <= s2_bx0; s3_by0 <= s2_by0; s3_bx1 <= s2_bx1; s3_by1 <= s2_by1;
    s3_ux  <= s2_ux;
    s3_uy  <= s2_uy;
    s3_d   <= CW'(s2_uv1) - CW'(s2_uv2);
    s3_sn  <= CW'(s2_vw1) - CW'(s2_vw2);
    s3_tn  <= CW'(s2_uw1) - CW'(s2_uw2);
    s3_dis <= s2_n0 > s2_dn || s2_n1 < 0;
    s3_lob <= s2_n0 < 0;
    s3_hib <= s2_n1 > s2_dn;
    s3_ceq <= c0 == c1;
    s3_sw  <= s2_sw;
    s3_upt <= s2_upt;
    s3_vpt <= s2_vpt;
    s3_wa  <= s2_wa;
    s3_wb  <= s2_wb;
    s3_eqp <= s2_eqp;
  end

  // classification, handed to the queue
  logic                 ina, inb, dneg, sneg;
  logic signed [CW-1:0] sn_m, d_m;

  always_comb begin
    dneg = s3_d < 0;
    sneg = s3_sn < 0;
    if (dneg) begin
      ina = s3_sn <= 0 && s3_sn >= s3_d;
      inb = s3_tn <= 0 && s3_tn >= s3_d;
    end else begin
      ina = s3_sn >= 0 && s3_sn <= s3_d;
      inb = s3_tn >= 0 && s3_tn <= s3_d;
    end
    sn_m = sneg ? -s3_sn : s3_sn;
    d_m  = dneg ? -s3_d : s3_d;
    num  = sn_m[MW-1:0];
    den  = d_m[MW-1:0];
    dirx = s3_ux[DW-1] ? CB'(-s3_ux) : CB'(s3_ux);
    diry = s3_uy[DW-1] ? CB'(-s3_uy) : CB'(s3_uy);
    negx = (s3_ux[DW-1] ^ sneg ^ dneg) && s3_ux != '0 && s3_sn != '0;
    negy = (s3_uy[DW-1] ^ sneg ^ dneg) && s3_uy != '0 && s3_sn != '0;

    line = 1'b0;
    rel  = REL_DISJOINT;
    px   = s3_ax0;
    py   = s3_ay0;
    hx   = s3_ax1;
    hy   = s3_ay1;
    if (s3_d != '0) begin
      line = 1'b1;
      if (ina && inb)  rel = REL_POINT;
      else if (ina)    rel = REL_A_HIT;
      else if (inb)    rel = REL_B_HIT;
      else             rel = REL_LINES;
    end else if (s3_sn != '0 || s3_tn != '0) begin
      rel = REL_DISJOINT;
    end else if (s3_upt && s3_vpt) begin
      if (s3_eqp) rel = REL_POINT;
    end else if (s3_upt) begin
      if (s3_wa) rel = REL_POINT;
    end else if (s3_vpt) begin
      if (s3_wb) begin
        rel = REL_POINT;
        px  = s3_bx0;
        py  = s3_by0;
      end
    end else if (!s3_dis) begin
      rel = s3_ceq ? REL_POINT : REL_OVERLAP;
      if (s3_lob) begin
        px = s3_bx0; py = s3_by0;
      end else if (s3_sw) begin
        px = s3_ax1; py = s3_ay1;
      end
      if (s3_hib) begin
        hx = s3_bx1; hy = s3_by1;
      end else if (s3_sw) begin
        hx = s3_ax0; hy = s3_ay0;
      end
    end
  end

  assign out_valid = s3_v;

endmodule

/* design/sic_queue.sv */
module sic_queue import sic_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QDEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       rvalid,
  output logic [WIDTH-1:0]           rdata,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  q_ctl_t           ctl;

  // the back end never stalls, so any held request leaves at once
  assign ctl.push = push;
  assign ctl.pop  = count != '0;

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr] <= wdata;
    end
    if (ctl.pop) begin
      rdata <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= ctl.pop;
      if (ctl.push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (ctl.pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(ctl.push) - CW'(ctl.pop);
    end
  end

endmodule

/* design/sic_back.sv */
module sic_back import sic_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [2:0]                   rel,
  input  logic                         line,
  input  logic                         negx,
  input  logic                         negy,
  input  logic [COORD_BITS-1:0]        dirx,
  input  logic [COORD_BITS-1:0]        diry,
  input  logic [2*COORD_BITS+1:0]      num,
  input  logic [2*COORD_BITS+1:0]      den,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] hx,
  input  logic signed [COORD_BITS-1:0] hy,
  output logic                         valid,
  output logic [2:0]                   relation,
  output logic signed [OUT_BITS-1:0]   first_x,
  output logic signed [OUT_BITS-1:0]   first_y,
  output logic signed [OUT_BITS-1:0]   second_x,
  output logic signed [OUT_BITS-1:0]   second_y,
  output logic                         clipped
);

  localparam int CB = COORD_BITS;
  localparam int SW = OUT_BITS + 2;
  localparam logic signed [SW-1:0] SMAX = signed'({3'b000, {(OUT_BITS-1){1'b1}}});
  localparam logic signed [SW-1:0] SMIN = signed'({3'b111, {(OUT_BITS-1){1'b0}}});

  logic [OUT_BITS-1:0] qx, qy;
  logic                ovx, ovy;

  sic_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_divx (
    .clk(clk), .dir(dirx), .num(num), .den(den), .quo(qx), .ovf(ovx)
  );

  sic_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_divy (
    .clk(clk), .dir(diry), .num(num), .den(den), .quo(qy), .ovf(ovy)
  );

  logic                m_v    [0:DIV_LAT-1];
  logic [2:0]          m_rel  [0:DIV_LAT-1];
  logic                m_line [0:DIV_LAT-1];
  logic                m_nx   [0:DIV_LAT-1];
  logic                m_ny   [0:DIV_LAT-1];
  logic signed [CB-1:0] m_px  [0:DIV_LAT-1];
  logic signed [CB-1:0] m_py  [0:DIV_LAT-1];
  logic signed [CB-1:0] m_hx  [0:DIV_LAT-1];
  logic signed [CB-1:0] m_hy  [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) m_v[k] <= 1'b0;
    end else begin
      m_v[0] <= in_valid;
      for (int k = 1; k < DIV_LAT; k++) m_v[k] <= m_v[k-1];
    end
    m_rel[0] <= rel; m_line[0] <= line; m_nx[0] <= negx; m_ny[0] <= negy;
    m_px[0]  <= px;  m_py[0]   <= py;   m_hx[0] <= hx;   m_hy[0] <= hy;
    for (int k = 1; k < DIV_LAT; k++) begin
      m_rel[k] <= m_rel[k-1]; m_line[k] <= m_line[k-1];
      m_nx[k]  <= m_nx[k-1];  m_ny[k]   <= m_ny[k-1];
      m_px[k]  <= m_px[k-1];  m_py[k]   <= m_py[k-1];
      m_hx[k]  <= m_hx[k-1];  m_hy[k]   <= m_hy[k-1];
    end
  end

  // integer coordinate in output fixed point
  function automatic logic [OUT_BITS-1:0] fix(input logic signed [CB-1:0] p);
    logic signed [SW-1:0] s;
    s = SW'(p) <<< FRAC_BITS;
    return s[OUT_BITS-1:0];
  endfunction

  // base plus signed quotient, saturated; msb of result is the clip flag
  function automatic logic [OUT_BITS:0] sat(input logic signed [CB-1:0] p, input logic neg,
                                            input logic [OUT_BITS-1:0] q, input logic ov);
    logic signed [SW-1:0] b, qs, s;
    b  = SW'(p) <<< FRAC_BITS;
    qs = signed'({2'b00, q});
    s  = neg ? b - qs : b + qs;
    if (ov)             return {1'b1, neg ? SMIN[OUT_BITS-1:0] : SMAX[OUT_BITS-1:0]};
    else if (s > SMAX)  return {1'b1, SMAX[OUT_BITS-1:0]};
    else if (s < SMIN)  return {1'b1, SMIN[OUT_BITS-1:0]};
    else                return {1'b0, s[OUT_BITS-1:0]};
  endfunction

  localparam int L = DIV_LAT - 1;
  logic [OUT_BITS:0] rx, ry;

  always_comb begin
    rx = sat(m_px[L], m_nx[L], qx, ovx);
    ry = sat(m_py[L], m_ny[L], qy, ovy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= m_v[L];
    end
    relation <= m_rel[L];
    if (m_line[L]) begin
      first_x  <= rx[OUT_BITS-1:0];
      first_y  <= ry[OUT_BITS-1:0];
      second_x <= '0;
      second_y <= '0;
      clipped  <= rx[OUT_BITS] | ry[OUT_BITS];
    end else begin
      first_x  <= (m_rel[L] == REL_DISJOINT) ? '0 : fix(m_px[L]);
      first_y  <= (m_rel[L] == REL_DISJOINT) ? '0 : fix(m_py[L]);
      second_x <= (m_rel[L] == REL_OVERLAP) ? fix(m_hx[L]) : '0;
      second_y <= (m_rel[L] == REL_OVERLAP) ? fix(m_hy[L]) : '0;
      clipped  <= 1'b0;
    end
  end

endmodule

/* design/segment_intersection_classifier.sv */
// channel  | handshake           | payload
// request  | start, busy         | a_start_x .. b_end_y
// result   | valid (one cycle)   | relation, first_x/y, second_x/y, clipped
//
// One request per cycle while busy is low; a result passes the front stages,
// the queue, the bit-per-stage quotient pipeline in sic_div and an output register.
// Synchronous reset clears all valid bits and the queue.
// busy rises only when the queue could not absorb the requests in flight;
// the back end drains every cycle, so in practice it stays low.
// Results cannot be held off by the receiver.
module segment_intersection_classifier import sic_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] a_start_x,
  input  logic signed [COORD_BITS-1:0] a_start_y,
  input  logic signed [COORD_BITS-1:0] a_end_x,
  input  logic signed [COORD_BITS-1:0] a_end_y,
  input  logic signed [COORD_BITS-1:0] b_start_x,
  input  logic signed [COORD_BITS-1:0] b_start_y,
  input  logic signed [COORD_BITS-1:0] b_end_x,
  input  logic signed [COORD_BITS-1:0] b_end_y,
  output logic                         valid,
  output logic [2:0]                   relation,
  output logic signed [OUT_BITS-1:0]   first_x,
  output logic signed [OUT_BITS-1:0]   first_y,
  output logic signed [OUT_BITS-1:0]   second_x,
  output logic signed [OUT_BITS-1:0]   second_y,
  output logic                         clipped
);

  localparam int CB  = COORD_BITS;
  localparam int MW  = 2*CB + 2;
  localparam int EW  = 3 + 3 + 2*CB + 2*MW + 4*CB;
  localparam int QCW = $clog2(QDEPTH+1);

  logic              f_valid, f_line, f_negx, f_negy;
  logic [2:0]        f_rel;
  logic [CB-1:0]     f_dirx, f_diry;
  logic [MW-1:0]     f_num, f_den;
  logic signed [CB-1:0] f_px, f_py, f_hx, f_hy;

  logic              q_valid, q_line, q_negx, q_negy;
  logic [2:0]        q_rel;
  logic [CB-1:0]     q_dirx, q_diry;
  logic [MW-1:0]     q_num, q_den;
  logic signed [CB-1:0] q_px, q_py, q_hx, q_hy;

  logic [EW-1:0]     wdata, rdata;
  logic [QCW-1:0]    count;

  // leave room for everything the front may still hand over
  assign busy = count >= QCW'(QDEPTH - FRONT_LAT - 1);

  sic_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy),
    .ax0(a_start_x), .ay0(a_start_y), .ax1(a_end_x), .ay1(a_end_y),
    .bx0(b_start_x), .by0(b_start_y), .bx1(b_end_x), .by1(b_end_y),
    .out_valid(f_valid), .rel(f_rel), .line(f_line), .negx(f_negx), .negy(f_negy),
    .dirx(f_dirx), .diry(f_diry), .num(f_num), .den(f_den),
    .px(f_px), .py(f_py), .hx(f_hx), .hy(f_hy)
  );

  assign wdata = {f_rel, f_line, f_negx, f_negy, f_dirx, f_diry, f_num, f_den,
                  f_px, f_py, f_hx, f_hy};

  sic_queue #(.WIDTH(EW), .DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(f_valid), .wdata(wdata),
    .rvalid(q_valid), .rdata(rdata), .count(count)
  );

  assign {q_rel, q_line, q_negx, q_negy, q_dirx, q_diry, q_num, q_den,
          q_px, q_py, q_hx, q_hy} = rdata;

  sic_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .in_valid(q_valid), .rel(q_rel), .line(q_line),
    .negx(q_negx), .negy(q_negy), .dirx(q_dirx), .diry(q_diry),
    .num(q_num), .den(q_den), .px(q_px), .py(q_py), .hx(q_hx), .hy(q_hy),
    .valid(valid), .relation(relation), .first_x(first_x), .first_y(first_y),
    .second_x(second_x), .second_y(second_y), .clipped(clipped)
  );

endmodule

/* design/sic_checker.sv */
module sic_checker import sic_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       valid,
  input logic [2:0]                 relation,
  input logic signed [OUT_BITS-1:0] first_x,
  input logic signed [OUT_BITS-1:0] first_y,
  input logic signed [OUT_BITS-1:0] second_x,
  input logic signed [OUT_BITS-1:0] second_y,
  input logic                       clipped
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !valid)
    else $error("result strobe after reset");

  a_rel_code: assert property (@(posedge clk) disable iff (rst)
    valid |-> relation != 3'd6 && relation != 3'd7)
    else $error("relation code out of range");

  a_second_zero: assert property (@(posedge clk) disable iff (rst)
    valid && relation != REL_OVERLAP |-> second_x == '0 && second_y == '0)
    else $error("second point set outside overlap");

  a_disjoint_zero: assert property (@(posedge clk) disable iff (rst)
    valid && relation == REL_DISJOINT |-> first_x == '0 && first_y == '0 && !clipped)
    else $error("disjoint result carries a point");

  a_overlap_noclip: assert property (@(posedge clk) disable iff (rst)
    valid && relation == REL_OVERLAP |-> !clipped)
    else $error("overlap endpoints flagged as clipped");

endmodule

bind segment_intersection_classifier sic_checker u_chk (
  .clk(clk), .rst(rst), .valid(valid),
  .relation(relation), .first_x(first_x), .first_y(first_y),
  .second_x(second_x), .second_y(second_y), .clipped(clipped)
);
